// File: rtl/core/ctkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_pkg: shared types and constants of the touch key detector
// Calibration round sizes, register codes, reset values, the cell control
// and scan result bundles, and the one-hot controller states.
// ----------------------------------------------------------------------------
package ctkd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  // calibration round: ten samples, keep ranks 2..7, average over six
  localparam int CAL_COUNT     = 10;
  localparam int CAL_KEEP      = 6;
  localparam int CAL_LOW_RANK  = 2;
  localparam int CAL_HIGH_RANK = 8;

  localparam int FILL_W  = 4;
  localparam int RANK_W  = $clog2(CAL_HIGH_RANK);
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SPS_W   = 4;
  localparam int LOCK_W  = 4;

  localparam logic [CFG_W-1:0]  GATE_RST    = 16'd100;
  localparam logic [CFG_W-1:0]  CNT_MAX_RST = 16'hFFFF;
  localparam logic [SPS_W-1:0]  SPS_RST     = 4'd3;
  localparam logic [LOCK_W-1:0] RELOAD_RST  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE    = 2'd0,
    REG_CNT_MAX = 2'd1,
    REG_SPS     = 2'd2,
    REG_RELOAD  = 2'd3
  } ctkd_reg_e;

  typedef enum logic {
    REQ_SCAN = 1'b0,
    REQ_CAL  = 1'b1
  } ctkd_req_e;

  typedef enum logic {
    RES_SCAN = 1'b0,
    RES_CAL  = 1'b1
  } ctkd_res_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } ctkd_state_e;

  typedef struct packed {
    logic insert;
    logic drain;
  } ctkd_cell_ctrl_t;

  typedef struct packed {
    logic done;
    logic pressed;
  } ctkd_scan_res_t;

endpackage
`default_nettype wire

// File: rtl/core/capacitive_touch_key_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capacitive_touch_key_detector: pad baseline calibration and touch detect
// Calibration samples are sorted into a chain of ten cells; the middle six
// ranks are averaged into the baseline. Scan samples form groups whose peak
// is compared against baseline plus gate.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with req_type_i and
//   charge_count_i; results leave on out_valid_o/out_ready_i from an output
//   register. Registers are written on cfg_valid_i/cfg_ready_o (always ready).
//   A scan request or a non-final calibration request leaves the controller
//   idle; a scan request that closes a group loads the output register in
//   that cycle. The tenth calibration request inserts its sample, drains the
//   sorting chain into the accumulator in DRAIN, halves the sum and multiplies
//   it by a reciprocal of three in DIV (whose last step loads the baseline),
//   and loads the result in EMIT once the output register is free; only then
//   is the next request taken.
//   Requests are taken only while the controller is idle and the output
//   register is empty or being emptied, so a stalled receiver holds off new
//   requests; no result is lost or repeated.
//   Reset clears fills, baseline, peak, lockout, the registers to their
//   defaults, and the output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module capacitive_touch_key_detector #(
  parameter int COUNT_WIDTH = ctkd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                req_type_i,
  input  wire  [COUNT_WIDTH-1:0]             charge_count_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               result_kind_o,
  output logic                               pressed_o,
  output logic [COUNT_WIDTH-1:0]             peak_value_o,
  output logic [COUNT_WIDTH-1:0]             baseline_value_o,
  output logic                               calib_failed_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [ctkd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [ctkd_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int W      = COUNT_WIDTH;
  localparam int N      = ctkd_pkg::CAL_COUNT;
  localparam int FW     = ctkd_pkg::FILL_W;
  localparam int RW     = ctkd_pkg::RANK_W;
  localparam int CFG_W  = ctkd_pkg::CFG_W;
  localparam int CMP_W  = (W > CFG_W) ? W : CFG_W;

  // configuration registers
  logic [CFG_W-1:0]              gate_q, cnt_max_q;
  logic [ctkd_pkg::SPS_W-1:0]    sps_q;
  logic [ctkd_pkg::LOCK_W-1:0]   reload_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q    <= ctkd_pkg::GATE_RST;
      cnt_max_q <= ctkd_pkg::CNT_MAX_RST;
      sps_q     <= ctkd_pkg::SPS_RST;
      reload_q  <= ctkd_pkg::RELOAD_RST;
    end else if (cfg_valid_i) begin
      unique case (ctkd_pkg::ctkd_reg_e'(cfg_index_i))
        ctkd_pkg::REG_GATE:    gate_q    <= cfg_data_i;
        ctkd_pkg::REG_CNT_MAX: cnt_max_q <= cfg_data_i;
        ctkd_pkg::REG_SPS:     sps_q     <= cfg_data_i[ctkd_pkg::SPS_W-1:0];
        ctkd_pkg::REG_RELOAD:  reload_q  <= cfg_data_i[ctkd_pkg::LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  ctkd_pkg::ctkd_state_e state_q, state_d;
  logic [FW-1:0]  cal_fill_q, cal_fill_d;
  logic [RW-1:0]  rank_q, rank_d;
  logic [W+2:0]   acc_q, acc_d, acc_sum;
  logic [W-1:0]   baseline_q, baseline_d;
  logic           in_take, scan_take, cal_take, out_free, cal_last, drain_last;
  ctkd_pkg::ctkd_cell_ctrl_t cell_ctrl;

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == ctkd_pkg::ST_IDLE) && out_free;
  assign in_take    = in_valid_i && in_ready_o;
  assign scan_take  = in_take && (req_type_i == ctkd_pkg::REQ_SCAN);
  assign cal_take   = in_take && (req_type_i == ctkd_pkg::REQ_CAL);
  assign cal_last   = cal_fill_q == FW'(N - 1);
  assign drain_last = rank_q == RW'(ctkd_pkg::CAL_HIGH_RANK - 1);

  assign cell_ctrl.insert = cal_take;
  assign cell_ctrl.drain  = state_q == ctkd_pkg::ST_DRAIN;

  // sorting chain
  logic [W-1:0] cell_val [N];
  logic         cell_gt  [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] left_val, right_val;
    logic         left_gt;
    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end
    ctkd_sort_cell #(.W(W)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .key_i       (charge_count_i),
      .occ_i       (cal_fill_q > FW'(i)),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // add only the kept ranks as they leave the chain head
  assign acc_sum = (rank_q >= RW'(ctkd_pkg::CAL_LOW_RANK))
                 ? acc_q + (W+3)'(cell_val[0]) : acc_q;

  logic         div_done;
  logic [W-1:0] div_quo;

  ctkd_div6 #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cell_ctrl.drain && drain_last),
    .dividend_i (acc_sum),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ctkd_pkg::ctkd_scan_res_t scan_res;
  logic [W-1:0]             scan_peak;

  ctkd_scan #(.W(W)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (scan_take),
    .sample_i   (charge_count_i),
    .baseline_i (baseline_q),
    .gate_i     (gate_q),
    .sps_i      (sps_q),
    .reload_i   (reload_q),
    .res_o      (scan_res),
    .peak_o     (scan_peak)
  );

  // output register
  logic         out_valid_q, out_valid_d;
  logic         kind_q, kind_d, pressed_q, pressed_d, failed_q, failed_d;
  logic [W-1:0] peak_q, peak_d, base_out_q, base_out_d;
  logic         cal_fail;

  assign cal_fail = CMP_W'(baseline_q) > CMP_W'(cnt_max_q >> 1);

  always_comb begin
    state_d     = state_q;
    cal_fill_d  = cal_fill_q;
    rank_d      = rank_q;
    acc_d       = acc_q;
    baseline_d  = baseline_q;
    out_valid_d = out_valid_o && !out_ready_i;
    kind_d      = kind_q;
    pressed_d   = pressed_q;
    failed_d    = failed_q;
    peak_d      = peak_q;
    base_out_d  = base_out_q;
    unique case (state_q)
      ctkd_pkg::ST_IDLE: begin
        if (cal_take) begin
          if (cal_last) begin
            cal_fill_d = '0;
            rank_d     = '0;
            acc_d      = '0;
            state_d    = ctkd_pkg::ST_DRAIN;
          end else begin
            cal_fill_d = cal_fill_q + FW'(1);
          end
        end
        if (scan_take && scan_res.done) begin
          out_valid_d = 1'b1;
          kind_d      = ctkd_pkg::RES_SCAN;
          pressed_d   = scan_res.pressed;
          failed_d    = 1'b0;
          peak_d      = scan_peak;
          base_out_d  = baseline_q;
        end
      end
      ctkd_pkg::ST_DRAIN: begin
        acc_d  = acc_sum;
        rank_d = rank_q + RW'(1);
        if (drain_last) begin
          state_d = ctkd_pkg::ST_DIV;
        end
      end
      ctkd_pkg::ST_DIV: begin
        if (div_done) begin
          baseline_d = div_quo;
          state_d    = ctkd_pkg::ST_EMIT;
        end
      end
      ctkd_pkg::ST_EMIT: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = ctkd_pkg::RES_CAL;
          pressed_d   = 1'b0;
          failed_d    = cal_fail;
          peak_d      = '0;
          base_out_d  = baseline_q;
          state_d     = ctkd_pkg::ST_IDLE;
        end
      end
      default: state_d = ctkd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctkd_pkg::ST_IDLE;
      cal_fill_q  <= '0;
      rank_q      <= '0;
      baseline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_fill_q  <= cal_fill_d;
      rank_q      <= rank_d;
      baseline_q  <= baseline_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    kind_q     <= kind_d;
    pressed_q  <= pressed_d;
    failed_q   <= failed_d;
    peak_q     <= peak_d;
    base_out_q <= base_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign pressed_o        = pressed_q;
  assign peak_value_o     = peak_q;
  assign baseline_value_o = base_out_q;
  assign calib_failed_o   = failed_q;

endmodule
`default_nettype wire

// File: rtl/core/ctkd_sort_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_sort_cell: one cell of the calibration sorting chain
// Holds one sample. On insert, keeps its value or takes the left neighbor's
// value or the new key, so the chain stays ascending. On drain, shifts left.
// ----------------------------------------------------------------------------
module ctkd_sort_cell #(
  parameter int W = ctkd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                         clk_i,
  input  wire ctkd_pkg::ctkd_cell_ctrl_t ctrl_i,
  input  wire  [W-1:0]                key_i,
  input  wire                         occ_i,
  input  wire  [W-1:0]                left_val_i,
  input  wire                         left_gt_i,
  input  wire  [W-1:0]                right_val_i,
  output logic [W-1:0]                val_o,
  output logic                        gt_o
);

  logic [W-1:0] val_q, val_d;

  // empty cells count as larger than any key
  assign gt_o  = !occ_i || (val_q > key_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (gt_o) begin
        val_d = left_gt_i ? left_val_i : key_i;
      end
    end else if (ctrl_i.drain) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// File: rtl/core/ctkd_div6.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_div6: divide the kept-rank sum by the calibration keep count
// Halves the sum, then divides by three with a reciprocal multiply that is
// split into two half-width products, the low one registered first.
// ----------------------------------------------------------------------------
module ctkd_div6 #(
  parameter int W = ctkd_pkg::COUNT_WIDTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  wire  [W+2:0] dividend_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  // the sum of six ranks is below 6 * 2**W, so its half fits in W+2 bits
  localparam int YW        = W + 2;
  localparam int MW        = W + 2;
  localparam int LW        = MW / 2;
  localparam int HW        = MW - LW;
  localparam int PW        = YW + MW;
  localparam int SH        = W + 3;
  localparam int HALF_KEEP = ctkd_pkg::CAL_KEEP / 2;
  // ceil(2**SH / 3) gives the exact quotient for every half sum below 2**SH
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(HALF_KEEP - 1)) / 64'(HALF_KEEP);
  localparam logic [MW-1:0] M = MW'(RECIP);

  logic [YW-1:0]    y_q, y_d;
  logic [YW+LW-1:0] lo_q, lo_d, lo_prod;
  logic [YW+HW-1:0] hi_prod;
  logic [PW-1:0]    full_prod;
  logic             mul_q, fin_q;

  assign lo_prod   = (YW+LW)'(y_q) * (YW+LW)'(M[LW-1:0]);
  assign hi_prod   = (YW+HW)'(y_q) * (YW+HW)'(M[MW-1:LW]);
  assign full_prod = PW'(lo_q) + (PW'(hi_prod) << LW);

  always_comb begin
    y_d  = y_q;
    lo_d = lo_q;
    if (start_i) begin
      y_d = dividend_i[W+2:1];
    end
    if (mul_q) begin
      lo_d = lo_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      mul_q <= start_i;
      fin_q <= mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q  <= y_d;
    lo_q <= lo_d;
  end

  assign done_o     = fin_q;
  assign quotient_o = full_prod[SH +: W];

endmodule
`default_nettype wire

// File: rtl/core/ctkd_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_scan: scan group peak tracking and touch decision
// Tracks group fill, running peak and the lockout counter; flags the
// sample that closes a group together with its press decision.
// ----------------------------------------------------------------------------
module ctkd_scan #(
  parameter int W = ctkd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               take_i,
  input  wire  [W-1:0]                      sample_i,
  input  wire  [W-1:0]                      baseline_i,
  input  wire  [ctkd_pkg::CFG_W-1:0]        gate_i,
  input  wire  [ctkd_pkg::SPS_W-1:0]        sps_i,
  input  wire  [ctkd_pkg::LOCK_W-1:0]       reload_i,
  output ctkd_pkg::ctkd_scan_res_t          res_o,
  output logic [W-1:0]                      peak_o
);

  localparam int SUM_W = ((W > ctkd_pkg::CFG_W) ? W : ctkd_pkg::CFG_W) + 1;
  localparam int LW    = ctkd_pkg::LOCK_W;
  localparam int SW    = ctkd_pkg::SPS_W;

  logic [SW-1:0]    fill_q, fill_d, fill_inc, need;
  logic [W-1:0]     peak_q, peak_d, peak_new;
  logic [LW-1:0]    lock_q, lock_d;
  logic [SUM_W-1:0] limit;
  logic             hit;

  assign need     = (sps_i == '0) ? SW'(1) : sps_i;
  assign fill_inc = fill_q + SW'(1);
  assign peak_new = (sample_i > peak_q) ? sample_i : peak_q;
  assign limit    = SUM_W'(baseline_i) + SUM_W'(gate_i);
  assign hit      = SUM_W'(peak_new) > limit;

  assign res_o.done    = (fill_inc == '0) || (fill_inc >= need);
  assign res_o.pressed = hit && (lock_q == '0);
  assign peak_o        = peak_new;

  always_comb begin
    fill_d = fill_q;
    peak_d = peak_q;
    lock_d = lock_q;
    if (take_i) begin
      if (res_o.done) begin
        fill_d = '0;
        peak_d = '0;
        // reload on a hit, then count down once per decision
        if (hit) begin
          lock_d = (reload_i == '0) ? '0 : reload_i - LW'(1);
        end else if (lock_q != '0) begin
          lock_d = lock_q - LW'(1);
        end
      end else begin
        fill_d = fill_inc;
        peak_d = peak_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      peak_q <= '0;
      lock_q <= '0;
    end else begin
      fill_q <= fill_d;
      peak_q <= peak_d;
      lock_q <= lock_d;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_capacitive_touch_key_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_capacitive_touch_key_detector: self-checking bench of the touch detector
// Drives scan and calibration requests, predicts each scan decision and each
// calibration result in the bench, and compares every result field by field.
// A short directed table comes first, then phases of random requests under
// several register settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_capacitive_touch_key_detector;
  import ctkd_pkg::*;

  localparam int CW           = COUNT_WIDTH_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_GAP   = 40;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int N_DIRECTED   = 22;

  typedef struct packed {
    ctkd_res_e   kind;
    logic        pressed;
    logic [15:0] peak;
    logic [15:0] base;
    logic        failed;
  } touch_res_t;

  typedef enum logic [1:0] {
    CHK_NONE,
    CHK_PRED,
    CHK_TYPED
  } chk_e;

  typedef struct packed {
    ctkd_req_e   req;
    logic [15:0] cnt;
    chk_e        chk;
    touch_res_t  res;
  } dir_row_t;

  localparam touch_res_t NO_RES = '{RES_SCAN, 1'b0, 16'h0000, 16'h0000, 1'b0};

  // reset registers: gate 100, counter max 65535, group of 3, lockout 3
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{REQ_SCAN, 16'd0,     CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'hFFFF,  CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd5,     CHK_TYPED, '{RES_SCAN, 1'b1, 16'hFFFF, 16'd0, 1'b0}},
    '{REQ_SCAN, 16'd200,   CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd0,     CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd0,     CHK_PRED,  NO_RES},
    '{REQ_SCAN, 16'd100,   CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd50,    CHK_NONE,  NO_RES},
    // peak equal to baseline plus gate is not a touch
    '{REQ_SCAN, 16'd0,     CHK_TYPED, '{RES_SCAN, 1'b0, 16'd100, 16'd0, 1'b0}},
    '{REQ_CAL,  16'hFFFF,  CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd0,     CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd40000, CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd40150, CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd40000, CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'hFFFF,  CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd40000, CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd0,     CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd40000, CHK_NONE,  NO_RES},
    '{REQ_CAL,  16'd40000, CHK_NONE,  NO_RES},
    // outliers trimmed, sum of six wide values must not wrap
    '{REQ_CAL,  16'd40000, CHK_TYPED, '{RES_CAL, 1'b0, 16'd0, 16'd40000, 1'b1}},
    '{REQ_SCAN, 16'd40100, CHK_NONE,  NO_RES},
    '{REQ_SCAN, 16'd0,     CHK_PRED,  NO_RES}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [CW-1:0]        charge_count_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 result_kind_o;
  logic                 pressed_o;
  logic [CW-1:0]        peak_value_o;
  logic [CW-1:0]        baseline_value_o;
  logic                 calib_failed_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // detector copy: registers and state
  logic [15:0]       gate_cfg   = GATE_RST;
  logic [15:0]       cmax_cfg   = CNT_MAX_RST;
  logic [3:0]        sps_cfg    = SPS_RST;
  logic [3:0]        reload_cfg = RELOAD_RST;
  logic [15:0]       cal_buf [CAL_COUNT] = '{default: '0};
  int                cal_count  = 0;
  logic [15:0]       base_level = '0;
  logic [3:0]        grp_count  = '0;
  logic [15:0]       grp_peak   = '0;
  logic [3:0]        lock_cnt   = '0;

  touch_res_t        expected_results [$];
  int                n_errors      = 0;
  int                n_sent        = 0;
  int                n_scan_seen   = 0;
  int                n_press_seen  = 0;
  int                n_cal_seen    = 0;
  int                n_fail_seen   = 0;
  int                cycle_cnt     = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                cal_style     = 0;
  logic [15:0]       cal_target    = '0;

  capacitive_touch_key_detector #(
    .COUNT_WIDTH(CW)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .charge_count_i   (charge_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .pressed_o        (pressed_o),
    .peak_value_o     (peak_value_o),
    .baseline_value_o (baseline_value_o),
    .calib_failed_o   (calib_failed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] clamp16(input int v);
    return (v < 0) ? 16'h0000 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // advance the detector copy by one request
  function automatic void predict_touch(input ctkd_req_e req, input logic [15:0] cnt,
                                        output bit has_res, output touch_res_t res);
    logic [15:0] srt [CAL_COUNT];
    logic [15:0] key;
    logic [15:0] pk;
    logic [3:0]  need;
    int          j;
    int unsigned acc;
    has_res = 1'b0;
    res     = NO_RES;
    if (req == REQ_CAL) begin
      cal_buf[cal_count] = cnt;
      cal_count++;
      if (cal_count == CAL_COUNT) begin
        cal_count = 0;
        srt = cal_buf;
        for (int i = 1; i < CAL_COUNT; i++) begin
          key = srt[i];
          j = i - 1;
          while (j >= 0 && srt[j] > key) begin
            srt[j + 1] = srt[j];
            j--;
          end
          srt[j + 1] = key;
        end
        acc = 0;
        for (int i = CAL_LOW_RANK; i < CAL_HIGH_RANK; i++) acc += srt[i];
        base_level = 16'(acc / CAL_KEEP);
        res.kind   = RES_CAL;
        res.base   = base_level;
        res.failed = (base_level > (cmax_cfg >> 1));
        has_res    = 1'b1;
      end
    end else begin
      need = (sps_cfg == 4'd0) ? 4'd1 : sps_cfg;
      if (cnt > grp_peak) grp_peak = cnt;
      grp_count = grp_count + 4'd1;
      if (grp_count == 4'd0 || grp_count >= need) begin
        pk        = grp_peak;
        grp_count = '0;
        grp_peak  = '0;
        if ({1'b0, pk} > {1'b0, base_level} + {1'b0, gate_cfg}) begin
          if (lock_cnt == 4'd0) res.pressed = 1'b1;
          lock_cnt = reload_cfg;
        end
        if (lock_cnt != 4'd0) lock_cnt--;
        res.kind = RES_SCAN;
        res.peak = pk;
        res.base = base_level;
        has_res  = 1'b1;
      end
    end
  endfunction

  task automatic send_request(input ctkd_req_e req, input logic [15:0] cnt,
                              input chk_e chk, input touch_res_t typed);
    bit         has_res;
    touch_res_t pred;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    charge_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    predict_touch(req, cnt, has_res, pred);
    if (chk == CHK_TYPED) expected_results.push_back(typed);
    else if (chk == CHK_PRED && has_res) expected_results.push_back(pred);
  endtask

  // hold valid high across back-to-back writes; caller drops it
  task automatic write_reg(input ctkd_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_GATE:    gate_cfg   = data;
      REG_CNT_MAX: cmax_cfg   = data;
      REG_SPS:     sps_cfg    = data[3:0];
      REG_RELOAD:  reload_cfg = data[3:0];
    endcase
  endtask

  // wait for all expected results, then idle through the settle gap
  task automatic settle();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    touch_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d pressed %0d peak %0d baseline %0d",
               result_kind_o, pressed_o, peak_value_o, baseline_value_o);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("result_kind", exp_r.kind, result_kind_o);
        check_field("pressed", exp_r.pressed, pressed_o);
        check_field("peak_value", exp_r.peak, peak_value_o);
        check_field("baseline_value", exp_r.base, baseline_value_o);
        check_field("calib_failed", exp_r.failed, calib_failed_o);
        if (exp_r.kind == RES_CAL) begin
          n_cal_seen++;
          if (exp_r.failed) n_fail_seen++;
        end else begin
          n_scan_seen++;
          if (exp_r.pressed) n_press_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("capacitive_touch_key_detector test failed");
      $finish;
    end
  end

  initial begin
    ctkd_req_e   req;
    logic [15:0] cnt;
    logic [15:0] g_w, c_w, s_w, r_w;
    logic [16:0] thr;
    int          k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_SCAN;
    charge_count_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_GATE;
    cfg_data_i     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++)
      send_request(DIRECTED[r].req, DIRECTED[r].cnt, DIRECTED[r].chk, DIRECTED[r].res);
    in_valid_i <= 1'b0;
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        1: begin g_w = 16'd0; c_w = 16'hFFFF; s_w = 16'd1; r_w = 16'd0; end
        2: begin g_w = 16'hFFFF; c_w = 16'd1; s_w = 16'd15; r_w = 16'd15; end
        3: begin
          g_w = 16'($urandom_range(0, 400));
          c_w = 16'($urandom_range(1, 16'hFFFF));
          s_w = 16'd0;
          r_w = 16'($urandom_range(0, 15));
        end
        4: begin
          // upper data bits of the narrow registers are don't-care
          g_w = 16'($urandom);
          c_w = 16'($urandom_range(1, 16'hFFFF));
          s_w = (16'($urandom) & 16'hFFF0) | 16'($urandom_range(1, 15));
          r_w = 16'($urandom);
        end
        default: begin
          g_w = 16'($urandom_range(0, 200));
          c_w = 16'($urandom_range(1, 16'hFFFF));
          s_w = 16'($urandom_range(2, 6));
          r_w = 16'($urandom_range(1, 4));
        end
      endcase
      if (p != 0) begin
        write_reg(REG_GATE, g_w);
        write_reg(REG_CNT_MAX, c_w);
        write_reg(REG_SPS, s_w);
        write_reg(REG_RELOAD, r_w);
        cfg_valid_i <= 1'b0;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // finish open calibration rounds more often than starting new ones
        if ($urandom_range(0, 99) < ((cal_count != 0) ? 45 : 12)) begin
          req = REQ_CAL;
          if (cal_count == 0) begin
            cal_style  = $urandom_range(0, 3);
            cal_target = 16'($urandom_range(0, cmax_cfg));
          end
          case (cal_style)
            0: cnt = 16'($urandom);
            1: cnt = clamp16(int'(cal_target) + int'($urandom_range(0, 600)) - 300);
            2: cnt = cmax_cfg >> 1;
            default: cnt = (cmax_cfg >> 1) + 16'd1;
          endcase
          if ($urandom_range(0, 99) < 8) cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
          req = REQ_SCAN;
          k   = $urandom_range(0, 99);
          thr = {1'b0, base_level} + {1'b0, gate_cfg};
          if (k < 70) cnt = clamp16(int'(thr) + int'($urandom_range(0, 16)) - 8);
          else if (k < 85) cnt = 16'($urandom);
          else if (k < 90) cnt = 16'h0000;
          else if (k < 95) cnt = 16'hFFFF;
          else cnt = 16'($urandom_range(0, 255));
        end
        send_request(req, cnt, CHK_PRED, NO_RES);
      end
      in_valid_i <= 1'b0;
      settle();
    end

    $display("Sent %0d requests (%0d directed) over %0d register settings.",
             n_sent, N_DIRECTED, N_PHASES);
    $display("Checked %0d scan decisions (%0d presses), %0d calibrations (%0d failed).",
             n_scan_seen, n_press_seen, n_cal_seen, n_fail_seen);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("capacitive_touch_key_detector test passed");
    end else begin
      $display("capacitive_touch_key_detector test failed");
    end
    $finish;
  end

endmodule
